FILE: design/aapo_pkg.sv
// shared types and constants for the all-pairs box overlap core
`default_nettype none

package aapo_pkg;

   // coordinate and id widths of one box
   localparam int CoordW = 32;
   localparam int IdW    = 16;

   // action codes of an input item
   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_ADD   = 1'b1;

   // one axis-aligned box with the id of its body
   typedef struct packed {
      logic signed [CoordW-1:0] min_x;
      logic signed [CoordW-1:0] min_y;
      logic signed [CoordW-1:0] min_z;
      logic signed [CoordW-1:0] max_x;
      logic signed [CoordW-1:0] max_y;
      logic signed [CoordW-1:0] max_z;
      logic [IdW-1:0]           id;
   } box_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;    // latch the overlap result against the query box
      logic shift;   // take hit flag and id from the next cell
      logic write;   // store the query box in this cell
      logic in_use;  // cell holds a box of the current table
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/aapo_cell.sv
// one table cell: a stored box, its overlap test and one stage of the hit shift chain
`default_nettype none

module aapo_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire aapo_pkg::cell_ctrl_type ctrl,
   input  wire aapo_pkg::box_type      query,
   input  wire                         nbr_hit,
   input  wire  [aapo_pkg::IdW-1:0]    nbr_sid,
   output logic                        hit,
   output logic [aapo_pkg::IdW-1:0]    sid
);
   import aapo_pkg::*;

   box_type         box_ff;
   logic            hit_ff, hit_in;
   logic [IdW-1:0]  sid_ff, sid_in;
   logic            overlap;

   // boxes overlap unless some axis separates them strictly
   assign overlap = !((box_ff.min_x > query.max_x) || (box_ff.max_x < query.min_x) ||
                      (box_ff.min_y > query.max_y) || (box_ff.max_y < query.min_y) ||
                      (box_ff.min_z > query.max_z) || (box_ff.max_z < query.min_z));

   // load a fresh hit flag or shift toward the head of the chain
   always_comb begin
      hit_in = hit_ff;
      sid_in = sid_ff;
      priority if (ctrl.load) begin
         hit_in = ctrl.in_use && overlap;
         sid_in = box_ff.id;
      end else if (ctrl.shift) begin
         hit_in = nbr_hit;
         sid_in = nbr_sid;
      end else begin
         hit_in = hit_ff;
         sid_in = sid_ff;
      end
   end

   // hit flag is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   // stored box and shifted id
   always_ff @(posedge clock) begin
      sid_ff <= sid_in;
      if (ctrl.write) begin
         box_ff <= query;
      end
   end

   assign hit = hit_ff;
   assign sid = sid_ff;

endmodule

`default_nettype wire

FILE: design/aabb_all_pairs_overlap_core.sv
// top level: brute-force box overlap broadphase built as a chain of table cells
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------------
//  request | req_action, req_box_*, req_body_id     | taken when start && !busy
//  result  | rsp_pair_first/second, rsp_rejected,   | rsp_valid high one cycle,
//          | rsp_last                               | no back-pressure
//
// An add compares the new box against all stored boxes in parallel, one cell per box,
// and stores it. The hit flags then shift toward cell 0, one cell a cycle, and each
// hit at the head gives one pair: after it is taken an add stays busy until no hit
// remains behind the head. Clear and a rejected add leave busy low. Results are
// registered and show in the cycle after they are found. Reset empties the table;
// stored boxes need no clearing. The receiver cannot stall.
`default_nettype none

module aabb_all_pairs_overlap_core #(
   parameter int MAX_BOXES = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_action,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_min_x,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_min_y,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_min_z,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_max_x,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_max_y,
   input  wire  signed [aapo_pkg::CoordW-1:0] req_box_max_z,
   input  wire  [aapo_pkg::IdW-1:0]          req_body_id,
   output logic                              rsp_valid,
   output logic [aapo_pkg::IdW-1:0]          rsp_pair_first,
   output logic [aapo_pkg::IdW-1:0]          rsp_pair_second,
   output logic                              rsp_rejected,
   output logic                              rsp_last
);
   import aapo_pkg::*;

   localparam int CntW = $clog2(MAX_BOXES + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdW-1:0]  qid_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IdW-1:0]  rsp_first_ff, rsp_first_in;
   logic [IdW-1:0]  rsp_second_ff, rsp_second_in;
   logic            rsp_rej_ff, rsp_rej_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            accept, full, do_add, scanning, rest_any;
   box_type         query;
   logic [MAX_BOXES:0] hit_vec;
   logic [IdW-1:0]  sid_vec [MAX_BOXES+1];
   logic [IdW-1:0]  head_sid;

   assign busy     = (state_ff == ST_SCAN);
   assign scanning = (state_ff == ST_SCAN);
   assign accept   = start && !busy;
   assign full     = (count_ff == CntW'(MAX_BOXES));
   assign do_add   = accept && (req_action == ACT_ADD) && !full;

   // query box from the request ports
   always_comb begin
      query.min_x = req_box_min_x;
      query.min_y = req_box_min_y;
      query.min_z = req_box_min_z;
      query.max_x = req_box_max_x;
      query.max_y = req_box_max_y;
      query.max_z = req_box_max_z;
      query.id    = req_body_id;
   end

   // chain of cells, cell 0 is the oldest box and the head of the shift
   assign hit_vec[MAX_BOXES] = 1'b0;
   assign sid_vec[MAX_BOXES] = '0;

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      cell_ctrl_type ctrl;
      always_comb begin
         ctrl.load   = do_add;
         ctrl.shift  = scanning;
         ctrl.write  = do_add && (count_ff == CntW'(i));
         ctrl.in_use = (count_ff > CntW'(i));
      end
      aapo_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .query   (query),
         .nbr_hit (hit_vec[i+1]),
         .nbr_sid (sid_vec[i+1]),
         .hit     (hit_vec[i]),
         .sid     (sid_vec[i])
      );
   end

   assign head_sid = sid_vec[0];
   assign rest_any = |hit_vec[MAX_BOXES-1:1];

   // sequencer, count and result stage
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_CLEAR) begin
                  count_in = '0;
               end else if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_first_in  = '0;
                  rsp_second_in = '0;
                  rsp_rej_in    = 1'b1;
                  rsp_last_in   = 1'b1;
               end else begin
                  count_in = count_ff + CntW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit_vec[0]) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = 1'b0;
               rsp_last_in  = !rest_any;
               if (qid_ff <= head_sid) begin
                  rsp_first_in  = qid_ff;
                  rsp_second_in = head_sid;
               end else begin
                  rsp_first_in  = head_sid;
                  rsp_second_in = qid_ff;
               end
            end
            if (!rest_any) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (do_add) begin
         qid_ff <= req_body_id;
      end
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pair_first  = rsp_first_ff;
   assign rsp_pair_second = rsp_second_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_last        = rsp_last_ff;

   // a rejected item is always the only and last result
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rej_ff |-> rsp_last_ff)
      else $error("rejected result without last");

   // pairs leave ordered by id
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_rej_ff |-> (rsp_first_ff <= rsp_second_ff))
      else $error("pair ids out of order");

   // the scan ends once no hit remains behind the head
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !rest_any |=> (state_ff == ST_IDLE))
      else $error("scan did not end after last hit");

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_BOXES))
      else $error("box count beyond table size");

endmodule

`default_nettype wire
